// ===== rtl/lcsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsm_pkg
// Shared types and constants for the li chao segment max block.
// ----------------------------------------------------------------------------
package lcsm_pkg;

	localparam int SLOPE_W = 32;
	localparam int ICPT_W  = 48;
	localparam int VAL_W   = 64;
	localparam int POS_W   = 10;
	localparam int LINE_W  = SLOPE_W + ICPT_W;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_T_VISIT,
		ST_T_CLIMB,
		ST_O_RD,
		ST_O_LAT,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M_CMP,
		ST_L0,
		ST_L1,
		ST_L2,
		ST_L_CMP,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_H_CMP,
		ST_Q_RD,
		ST_Q_LAT,
		ST_Q_MUL,
		ST_Q_ADD
	} state_t;

	typedef enum logic [1:0] {PT_MID, PT_LO, PT_HI, PT_X} pt_sel_t;
	typedef enum logic {LN_STORED, LN_NEW} ln_sel_t;
	typedef enum logic [1:0] {TR_HOLD, TR_DOWN, TR_UP, TR_SIB} trav_op_t;
	typedef enum logic [1:0] {OF_HOLD, OF_START, OF_LEFT, OF_RIGHT} offer_op_t;

	typedef struct packed {
		logic      clr_step;
		logic      load;
		trav_op_t  trav_op;
		offer_op_t offer_op;
		logic      mem_rd;
		logic      rd_offer;
		logic      latch;
		logic      mul;
		pt_sel_t   pt_sel;
		ln_sel_t   ln_sel;
		logic      add_a;
		logic      add_b;
		logic      swap_wr;
		logic      q_acc;
		logic      q_step;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rev_range;
		logic disjoint;
		logic covered;
		logic root;
		logic right_child;
		logic o_leaf;
		logic a_lt_b;
		logic q_leaf;
		logic out_full;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/lcsm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsm request and response channels
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface lcsm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [9:0]  range_start;
	logic [9:0]  range_end;
	logic signed [31:0] slope;
	logic signed [47:0] intercept;
	logic [9:0]  query_pos;

	modport source (output valid, req_type, range_start, range_end, slope, intercept,
		query_pos, input ready);
	modport sink (input valid, req_type, range_start, range_end, slope, intercept,
		query_pos, output ready);
endinterface

interface lcsm_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] max_value;

	modport source (output valid, max_value, input ready);
	modport sink (input valid, max_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsm_ctrl
// Sequencer for clearing, segment-cover walk, line offering and queries.
// ----------------------------------------------------------------------------
module lcsm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_type,
	input  wire lcsm_pkg::stat_t stat,
	output lcsm_pkg::cmd_t       cmd,
	output logic                 ready
);
	import lcsm_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_type == REQ_QUERY) state_nxt = ST_Q_RD;
					else if (!stat.rev_range) state_nxt = ST_T_VISIT;
				end
			end
			ST_T_VISIT: begin
				if (stat.disjoint) state_nxt = ST_T_CLIMB;
				else if (stat.covered) state_nxt = ST_O_RD;
			end
			ST_T_CLIMB: begin
				if (stat.root) state_nxt = ST_IDLE;
				else if (!stat.right_child) state_nxt = ST_T_VISIT;
			end
			ST_O_RD:  state_nxt = ST_O_LAT;
			ST_O_LAT: state_nxt = ST_M0;
			ST_M0:    state_nxt = ST_M1;
			ST_M1:    state_nxt = ST_M2;
			ST_M2:    state_nxt = ST_M_CMP;
			ST_M_CMP: state_nxt = stat.o_leaf ? ST_T_CLIMB : ST_L0;
			ST_L0:    state_nxt = ST_L1;
			ST_L1:    state_nxt = ST_L2;
			ST_L2:    state_nxt = ST_L_CMP;
			ST_L_CMP: state_nxt = stat.a_lt_b ? ST_O_RD : ST_H0;
			ST_H0:    state_nxt = ST_H1;
			ST_H1:    state_nxt = ST_H2;
			ST_H2:    state_nxt = ST_H_CMP;
			ST_H_CMP: state_nxt = stat.a_lt_b ? ST_O_RD : ST_T_CLIMB;
			ST_Q_RD:  state_nxt = ST_Q_LAT;
			ST_Q_LAT: state_nxt = ST_Q_MUL;
			ST_Q_MUL: state_nxt = ST_Q_ADD;
			ST_Q_ADD: begin
				if (!stat.q_leaf) state_nxt = ST_Q_RD;
				else if (!stat.out_full) state_nxt = ST_IDLE;
			end
			default:  state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd   = '0;
		ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				ready    = 1'b1;
				cmd.load = in_valid;
			end
			ST_T_VISIT: begin
				if (stat.disjoint) cmd.trav_op = TR_HOLD;
				else if (stat.covered) cmd.offer_op = OF_START;
				else cmd.trav_op = TR_DOWN;
			end
			ST_T_CLIMB: begin
				if (stat.root) cmd.trav_op = TR_HOLD;
				else if (stat.right_child) cmd.trav_op = TR_UP;
				else cmd.trav_op = TR_SIB;
			end
			ST_O_RD: begin
				cmd.mem_rd   = 1'b1;
				cmd.rd_offer = 1'b1;
			end
			ST_O_LAT: cmd.latch = 1'b1;
			ST_M0: begin
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_MID;
				cmd.ln_sel = LN_STORED;
			end
			ST_M1: begin
				cmd.add_a  = 1'b1;
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_MID;
				cmd.ln_sel = LN_NEW;
			end
			ST_M2:    cmd.add_b = 1'b1;
			ST_M_CMP: cmd.swap_wr = stat.a_lt_b;
			ST_L0: begin
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_LO;
				cmd.ln_sel = LN_STORED;
			end
			ST_L1: begin
				cmd.add_a  = 1'b1;
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_LO;
				cmd.ln_sel = LN_NEW;
			end
			ST_L2:    cmd.add_b = 1'b1;
			ST_L_CMP: begin
				if (stat.a_lt_b) cmd.offer_op = OF_LEFT;
			end
			ST_H0: begin
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_HI;
				cmd.ln_sel = LN_STORED;
			end
			ST_H1: begin
				cmd.add_a  = 1'b1;
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_HI;
				cmd.ln_sel = LN_NEW;
			end
			ST_H2:    cmd.add_b = 1'b1;
			ST_H_CMP: begin
				if (stat.a_lt_b) cmd.offer_op = OF_RIGHT;
			end
			ST_Q_RD:  cmd.mem_rd = 1'b1;
			ST_Q_LAT: cmd.latch = 1'b1;
			ST_Q_MUL: begin
				cmd.mul    = 1'b1;
				cmd.pt_sel = PT_X;
				cmd.ln_sel = LN_STORED;
			end
			ST_Q_ADD: begin
				cmd.q_acc = 1'b1;
				if (!stat.q_leaf) cmd.q_step = 1'b1;
				else cmd.out_load = !stat.out_full;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/lcsm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcsm_dp
// Node memory, walk registers, line evaluator and result register.
// ----------------------------------------------------------------------------
module lcsm_dp #(
	parameter int POSITIONS = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lcsm_pkg::cmd_t         cmd,
	output lcsm_pkg::stat_t             stat,
	input  wire logic [9:0]             range_start,
	input  wire logic [9:0]             range_end,
	input  wire logic signed [31:0]     slope,
	input  wire logic signed [47:0]     intercept,
	input  wire logic [9:0]             query_pos,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic signed [63:0]          max_value
);
	import lcsm_pkg::*;

	localparam int PW    = $clog2(POSITIONS);
	localparam int AW    = PW + 1;
	localparam int NODES = 2 ** AW;
	localparam int CW    = (PW > POS_W) ? PW : POS_W;
	localparam int DW    = $clog2(PW + 1);
	localparam int PRW   = SLOPE_W + CW + 1;

	// node memory, line word is {slope, intercept}
	logic [LINE_W-1:0] mem [NODES];
	logic [LINE_W-1:0] mem_rd_q;
	logic [AW-1:0]     clr_cnt_q;

	// request word
	logic [POS_W-1:0]         a_q, b_q, x_q;
	logic signed [SLOPE_W-1:0] ins_k_q;
	logic signed [ICPT_W-1:0]  ins_c_q;

	// cover walk / query walk
	logic [AW-1:0] u_t_q;
	logic [PW-1:0] lo_t_q, hi_t_q;
	logic [DW-1:0] depth_q;
	logic [PW-1:0] stack_q [PW+1];

	// offer descent
	logic [AW-1:0] u_o_q;
	logic [PW-1:0] lo_o_q, hi_o_q;
	logic signed [SLOPE_W-1:0] k_q, sk_q;
	logic signed [ICPT_W-1:0]  c_q, sc_q;

	logic signed [PRW-1:0]   prod_q;
	logic signed [VAL_W-1:0] va_q, vb_q, best_q, out_q;
	logic                    out_vld_q;

	logic [PW:0]   sum_t, sum_o;
	logic [PW-1:0] mid_t, mid_o;
	logic [CW-1:0] xv;
	logic signed [SLOPE_W-1:0] mul_k;
	logic signed [VAL_W-1:0]   prod_ext, q_val, best_nxt;
	logic [DW-1:0] depth_m1;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [LINE_W-1:0] wdata;

	assign sum_t    = {1'b0, lo_t_q} + {1'b0, hi_t_q};
	assign sum_o    = {1'b0, lo_o_q} + {1'b0, hi_o_q};
	assign mid_t    = sum_t[PW:1];
	assign mid_o    = sum_o[PW:1];
	assign depth_m1 = depth_q - 1'b1;

	always_comb begin
		unique case (cmd.pt_sel)
			PT_MID:  xv = CW'(mid_o);
			PT_LO:   xv = CW'(lo_o_q);
			PT_HI:   xv = CW'(hi_o_q);
			PT_X:    xv = CW'(x_q);
			default: xv = CW'(x_q);
		endcase
	end

	assign mul_k    = (cmd.ln_sel == LN_NEW) ? k_q : sk_q;
	assign prod_ext = {{(VAL_W-PRW){prod_q[PRW-1]}}, prod_q};
	assign q_val    = prod_ext + {{(VAL_W-ICPT_W){sc_q[ICPT_W-1]}}, sc_q};
	assign best_nxt = (q_val > best_q) ? q_val : best_q;

	// status
	assign stat.clr_last    = &clr_cnt_q;
	assign stat.rev_range   = range_start > range_end;
	assign stat.disjoint    = (CW'(b_q) < CW'(lo_t_q)) || (CW'(hi_t_q) < CW'(a_q));
	assign stat.covered     = (CW'(a_q) <= CW'(lo_t_q)) && (CW'(hi_t_q) <= CW'(b_q));
	assign stat.root        = u_t_q == '0;
	assign stat.right_child = (u_t_q != '0) && !u_t_q[0];
	assign stat.o_leaf      = lo_o_q == hi_o_q;
	assign stat.a_lt_b      = va_q < vb_q;
	assign stat.q_leaf      = lo_t_q == hi_t_q;
	assign stat.out_full    = out_vld_q;

	// memory port
	assign we    = cmd.clr_step || cmd.swap_wr;
	assign waddr = cmd.clr_step ? clr_cnt_q : u_o_q;
	assign wdata = cmd.clr_step ? {{SLOPE_W{1'b0}}, {ICPT_W{1'b1}}} : {k_q, c_q};
	assign raddr = cmd.rd_offer ? u_o_q : u_t_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.mem_rd) mem_rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// request capture and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= range_start;
			b_q     <= range_end;
			x_q     <= query_pos;
			ins_k_q <= slope;
			ins_c_q <= intercept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_t_q   <= '0;
			lo_t_q  <= '0;
			hi_t_q  <= '0;
			depth_q <= '0;
		end else if (cmd.load) begin
			u_t_q   <= '0;
			lo_t_q  <= '0;
			hi_t_q  <= PW'(POSITIONS - 1);
			depth_q <= '0;
		end else if (cmd.q_step) begin
			if (CW'(x_q) <= CW'(mid_t)) begin
				u_t_q  <= {u_t_q[AW-2:0], 1'b1};
				hi_t_q <= mid_t;
			end else begin
				u_t_q  <= {u_t_q[AW-2:0], 1'b0} + 2'd2;
				lo_t_q <= mid_t + 1'b1;
			end
		end else begin
			unique case (cmd.trav_op)
				TR_DOWN: begin
					u_t_q   <= {u_t_q[AW-2:0], 1'b1};
					hi_t_q  <= mid_t;
					depth_q <= depth_q + 1'b1;
				end
				TR_UP: begin
					u_t_q   <= (u_t_q - 1'b1) >> 1;
					depth_q <= depth_m1;
				end
				TR_SIB: begin
					u_t_q  <= u_t_q + 1'b1;
					lo_t_q <= hi_t_q + 1'b1;
					hi_t_q <= stack_q[depth_m1];
				end
				TR_HOLD: ;
				default: ;
			endcase
		end
	end

	// parent upper bounds of left descents
	always_ff @(posedge clk) begin
		if (cmd.trav_op == TR_DOWN) stack_q[depth_q] <= hi_t_q;
	end

	// offer descent and evaluator
	always_ff @(posedge clk) begin
		unique case (cmd.offer_op)
			OF_START: begin
				u_o_q  <= u_t_q;
				lo_o_q <= lo_t_q;
				hi_o_q <= hi_t_q;
				k_q    <= ins_k_q;
				c_q    <= ins_c_q;
			end
			OF_LEFT: begin
				u_o_q  <= {u_o_q[AW-2:0], 1'b1};
				hi_o_q <= mid_o;
			end
			OF_RIGHT: begin
				u_o_q  <= {u_o_q[AW-2:0], 1'b0} + 2'd2;
				lo_o_q <= mid_o + 1'b1;
			end
			OF_HOLD: ;
			default: ;
		endcase
		if (cmd.latch) begin
			sk_q <= mem_rd_q[LINE_W-1:ICPT_W];
			sc_q <= mem_rd_q[ICPT_W-1:0];
		end else if (cmd.swap_wr) begin
			// the incoming line wins the node, the old one keeps descending
			sk_q <= k_q;
			sc_q <= c_q;
			k_q  <= sk_q;
			c_q  <= sc_q;
		end
		if (cmd.mul) prod_q <= mul_k * $signed({1'b0, xv});
		if (cmd.add_a) va_q <= q_val;
		if (cmd.add_b) vb_q <= prod_ext + {{(VAL_W-ICPT_W){c_q[ICPT_W-1]}}, c_q};
		if (cmd.load) best_q <= {1'b1, {(VAL_W-1){1'b0}}};
		else if (cmd.q_acc) best_q <= best_nxt;
		if (cmd.out_load) out_q <= best_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign max_value = out_q;

endmodule
`default_nettype wire

// ===== rtl/li_chao_segment_max.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// li_chao_segment_max
// Li Chao segment tree, max form: segment inserts and point queries.
// ----------------------------------------------------------------------------
// channel  dir  carries
// req      in   req_type, range_start, range_end, slope, intercept, query_pos
// rsp      out  max_value, one word per query
//
// query: each tree level takes a node memory read, a latch, a multiply on the
//   single evaluator multiplier and an accumulate into the running max.
// insert: a cover walk finds the covered nodes, and at each one an offered
//   line descends, compared at mid, then at low and, where needed, high (mid,
//   low and high evaluations share one multiplier).
// after reset a clearing pass writes all 2*2^clog2(POSITIONS) nodes, one per
//   cycle, with req.ready low.
// a finished result waits in the output register; a later query stalls at
//   its last step until that word is taken.
// ----------------------------------------------------------------------------
module li_chao_segment_max #(
	parameter int POSITIONS = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	lcsm_req_if.sink   req,
	lcsm_rsp_if.source rsp
);
	import lcsm_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  ready;

	lcsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.ready    (ready)
	);

	lcsm_dp #(
		.POSITIONS (POSITIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.range_start (req.range_start),
		.range_end   (req.range_end),
		.slope       (req.slope),
		.intercept   (req.intercept),
		.query_pos   (req.query_pos),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.max_value   (rsp.max_value)
	);

	assign req.ready = ready;

`ifndef SYNTH
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !req.ready)
		else $error("request taken during clearing pass");

	a_insert_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == REQ_INSERT && !rsp.valid) |=> !rsp.valid)
		else $error("insert produced a result word");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_wr |-> !req.ready)
		else $error("node written while idle");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks li_chao_segment_max. A behavioral Li Chao tree predicts each query
// word, and the words the block returns are compared in order. The request
// side sends in random bursts and the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import lcsm_pkg::*;

	localparam int NPOS      = 1024;
	localparam int TREE_SIZE = 4 * NPOS;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic clk;
	logic arst_n;

	lcsm_req_if req ();
	lcsm_rsp_if rsp ();

	li_chao_segment_max #(.POSITIONS(NPOS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	longint tree_slope [TREE_SIZE];
	longint tree_icpt [TREE_SIZE];
	longint max_q [$];

	int     mismatches;
	int     unexpected;
	int     words_seen;
	int     inserts_sent;
	int     queries_sent;
	longint cycles;
	int     burst_left;
	int     stall_mode;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint line_val(longint k, longint c, longint x);
		return k * x + c;
	endfunction

	// keep the line that wins at the midpoint, push the loser down one side
	function automatic void place_line(int u, longint lo, longint hi, longint k, longint c);
		longint mid, sk, sc;
		while (u < TREE_SIZE) begin
			mid = (lo + hi) / 2;
			sk = tree_slope[u];
			sc = tree_icpt[u];
			if (line_val(sk, sc, mid) < line_val(k, c, mid)) begin
				tree_slope[u] = k;
				tree_icpt[u] = c;
				k = sk;
				c = sc;
				sk = tree_slope[u];
				sc = tree_icpt[u];
			end
			if (lo == hi)
				return;
			if (line_val(sk, sc, lo) < line_val(k, c, lo)) begin
				u = 2 * u + 1;
				hi = mid;
			end else if (line_val(sk, sc, hi) < line_val(k, c, hi)) begin
				u = 2 * u + 2;
				lo = mid + 1;
			end else begin
				return;
			end
		end
	endfunction

	function automatic void spread_segment(int u, longint lo, longint hi, longint a,
		longint b, longint k, longint c);
		longint mid;
		if (u >= TREE_SIZE || b < lo || hi < a)
			return;
		if (a <= lo && hi <= b) begin
			place_line(u, lo, hi, k, c);
			return;
		end
		mid = (lo + hi) / 2;
		spread_segment(2 * u + 1, lo, mid, a, b, k, c);
		spread_segment(2 * u + 2, mid + 1, hi, a, b, k, c);
	endfunction

	function automatic longint path_max(longint x);
		longint lo, hi, mid, best, v;
		int u;
		lo = 0;
		hi = NPOS - 1;
		u = 0;
		best = line_val(tree_slope[0], tree_icpt[0], x);
		while (lo != hi) begin
			mid = (lo + hi) / 2;
			if (x <= mid) begin
				u = 2 * u + 1;
				hi = mid;
			end else begin
				u = 2 * u + 2;
				lo = mid + 1;
			end
			if (u >= TREE_SIZE)
				break;
			v = line_val(tree_slope[u], tree_icpt[u], x);
			if (v > best)
				best = v;
		end
		return best;
	endfunction

	// one request word; valid stays high across back-to-back words
	task automatic send_word(logic kind, logic [9:0] rs, logic [9:0] re,
		logic signed [31:0] k, logic signed [47:0] c, logic [9:0] qp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.req_type    <= kind;
		req.range_start <= rs;
		req.range_end   <= re;
		req.slope       <= k;
		req.intercept   <= c;
		req.query_pos   <= qp;
		req.valid       <= 1'b1;
		do @(posedge clk); while (!req.ready);
		if (kind == REQ_INSERT) begin
			inserts_sent++;
			spread_segment(0, 0, NPOS - 1, rs, re, k, c);
		end else begin
			queries_sent++;
			max_q.push_back(path_max(qp));
		end
	endtask

	task automatic insert_seg(logic [9:0] rs, logic [9:0] re, logic signed [31:0] k,
		logic signed [47:0] c);
		send_word(REQ_INSERT, rs, re, k, c, 10'($urandom));
	endtask

	task automatic query_at(logic [9:0] qp);
		send_word(REQ_QUERY, 10'($urandom), 10'($urandom), 32'($urandom),
			48'({$urandom, $urandom}), qp);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (max_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic test_empty_tree();
		query_at(10'd0);
		query_at(10'd1023);
		query_at(10'd511);
	endtask

	task automatic test_extremes();
		insert_seg(10'd0, 10'd1023, 32'sh7fffffff, 48'sh800000000000);
		query_at(10'd0);
		query_at(10'd1023);
		insert_seg(10'd0, 10'd1023, 32'sh80000000, 48'sh7fffffffffff);
		query_at(10'd0);
		query_at(10'd1023);
		query_at(10'd600);
		// reversed range covers nothing
		insert_seg(10'd700, 10'd3, 32'sh7fffffff, 48'sh7fffffffffff);
		query_at(10'd300);
		// single position and the same line twice, tie keeps the stored one
		insert_seg(10'd1023, 10'd1023, 32'sd5, 48'sh7fff00000000);
		insert_seg(10'd1023, 10'd1023, 32'sd5, 48'sh7fff00000000);
		query_at(10'd1023);
		insert_seg(10'd0, 10'd0, -32'sd1, 48'sh7fffffffffff);
		query_at(10'd0);
		query_at(10'd1);
		insert_seg(10'd100, 10'd900, 32'sd0, 48'sd0);
		query_at(10'd500);
		wait_drained();
	endtask

	task automatic test_random_mix(int n);
		logic [9:0] a, b;
		logic signed [31:0] k;
		logic signed [47:0] c;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				a = 10'($urandom);
				case ($urandom_range(0, 3))
					0: b = 10'($urandom);
					1: b = (a > 10'd1000) ? 10'd1023 : a + 10'($urandom_range(0, 20));
					2: b = a;
					default: b = (a < 10'd10) ? 10'd0 : a - 10'($urandom_range(1, 9));
				endcase
				if ($urandom_range(0, 1)) begin
					k = 32'($urandom);
					c = 48'({$urandom, $urandom});
				end else begin
					// small lines compete, so losers really travel down
					k = 32'($signed($urandom_range(0, 200)) - 100);
					c = 48'($signed($urandom_range(0, 20000)) - 10000);
				end
				insert_seg(a, b, k, c);
			end else begin
				query_at(10'($urandom));
			end
		end
		wait_drained();
	endtask

	// response side: stall pattern is picked at random from four modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if (cycles % 300 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 1) == 0);
				2: rsp.ready <= ($urandom_range(0, 7) == 0);
				default: rsp.ready <= (cycles % 16) < 8;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			words_seen++;
			if (max_q.size() == 0) begin
				unexpected++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %0d", rsp.max_value);
			end else begin
				longint want;
				want = max_q.pop_front();
				if (rsp.max_value !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("max_value mismatch: expected %0d got %0d", want,
							rsp.max_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		unexpected = 0;
		words_seen = 0;
		inserts_sent = 0;
		queries_sent = 0;
		burst_left = 0;
		for (int i = 0; i < TREE_SIZE; i++) begin
			tree_slope[i] = 0;
			tree_icpt[i] = -1;
		end
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_INSERT;
		req.range_start = '0;
		req.range_end = '0;
		req.slope = '0;
		req.intercept = '0;
		req.query_pos = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tree();
		test_extremes();
		test_random_mix(1450);

		$display("sent %0d inserts and %0d queries, %0d result words checked",
			inserts_sent, queries_sent, words_seen);
		if (mismatches == 0 && max_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d unexpected, %0d words missing", mismatches,
				unexpected, max_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
